// File: rtl/mlnps_pkg.sv
`default_nettype none
package mlnps_pkg;

   localparam int MAX_HELD = 16;
   localparam int IDX_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int CNT_W    = $clog2(MAX_HELD + 1);

   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 16;
   localparam int VOUT_W   = 15;
   localparam int TOTAL_W  = 5;

   localparam logic [VOUT_W-1:0] VEL_FULL = VOUT_W'(16384);

   localparam logic MODE_ON  = 1'b0;
   localparam logic MODE_OFF = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/mlnps_ram.sv
`default_nettype none
module mlnps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/mlnps_ctrl.sv
`default_nettype none
module mlnps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output mlnps_pkg::cmd_type        cmd,
   input  wire mlnps_pkg::status_type status
);

   mlnps_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlnps_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mlnps_pkg::ST_SCAN;
            end
         end
         mlnps_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = mlnps_pkg::ST_FINISH;
            end
         end
         mlnps_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = mlnps_pkg::ST_IDLE;
            end
         end
         default: state_in = mlnps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         mlnps_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mlnps_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         mlnps_pkg::ST_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlnps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: rtl/mlnps_dp.sv
`default_nettype none
module mlnps_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mlnps_pkg::cmd_type                    cmd,
   output mlnps_pkg::status_type                      status,
   input  wire logic                                  req_mode,
   input  wire logic        [mlnps_pkg::NOTE_W-1:0]   req_note,
   input  wire logic signed [mlnps_pkg::VEL_W-1:0]    req_velocity,
   input  wire logic                                  req_voice_active,
   output logic             [mlnps_pkg::NOTE_W-1:0]   rsp_sounding_note,
   output logic                                       rsp_note_valid,
   output logic             [mlnps_pkg::VOUT_W-1:0]   rsp_velocity_out,
   output logic                                       rsp_pitch_update,
   output logic                                       rsp_restart_phase,
   output logic                                       rsp_gate_on,
   output logic                                       rsp_gate_off,
   output logic             [mlnps_pkg::TOTAL_W-1:0]  rsp_held_total
);

   // latched transaction
   logic                                mode_ff;
   logic [mlnps_pkg::NOTE_W-1:0]        note_ff;
   logic [mlnps_pkg::VEL_W-1:0]         vel_ff;
   logic                                active_ff;

   // scan pointers
   logic [mlnps_pkg::CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mlnps_pkg::CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic                        pend_ff, pend_in;
   logic [mlnps_pkg::NOTE_W-1:0] last_ff, last_in;

   // voice state
   logic [mlnps_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [mlnps_pkg::NOTE_W-1:0] cur_ff, cur_in;
   logic                         cur_valid_ff, cur_valid_in;
   logic [mlnps_pkg::VOUT_W-1:0] svel_ff, svel_in;

   // result flags
   logic pitch_in, restart_in, gon_in, goff_in;

   // memory port
   logic                         rd_ok;
   logic                         rd_en;
   logic [mlnps_pkg::NOTE_W-1:0] rd_data;
   logic                         scan_wr, finish_wr, wr_en;
   logic [mlnps_pkg::NOTE_W-1:0] wr_data;
   logic                         hit;
   logic [mlnps_pkg::VOUT_W-1:0] vel_clamped;

   assign rd_ok   = rd_ptr_ff < count_ff;
   assign rd_en   = cmd.scan && rd_ok;
   assign scan_wr = cmd.scan && pend_ff && (rd_data != note_ff);
   assign finish_wr = cmd.finish && (mode_ff == mlnps_pkg::MODE_ON)
                      && (wr_ptr_ff < mlnps_pkg::CNT_W'(mlnps_pkg::MAX_HELD));
   assign wr_en   = scan_wr || finish_wr;
   assign wr_data = scan_wr ? rd_data : note_ff;

   assign status.scan_done = (rd_ptr_ff == count_ff) && !pend_ff;

   mlnps_ram #(
      .WIDTH (mlnps_pkg::NOTE_W),
      .DEPTH (mlnps_pkg::MAX_HELD)
   ) u_held (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff[mlnps_pkg::IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[mlnps_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      pend_in   = 1'b0;
      last_in   = last_ff;
      if (cmd.load) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end else if (cmd.scan) begin
         pend_in = rd_ok;
         if (rd_ok) begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
         if (scan_wr) begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
            last_in   = rd_data;
         end
      end
   end

   always_comb begin
      if (vel_ff[mlnps_pkg::VEL_W-1]) begin
         vel_clamped = '0;
      end else if (vel_ff[mlnps_pkg::VEL_W-2:0] > mlnps_pkg::VEL_FULL) begin
         vel_clamped = mlnps_pkg::VEL_FULL;
      end else begin
         vel_clamped = vel_ff[mlnps_pkg::VOUT_W-1:0];
      end
   end

   assign hit = cur_valid_ff && (cur_ff == note_ff);

   always_comb begin
      count_in     = count_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      svel_in      = svel_ff;
      pitch_in     = 1'b0;
      restart_in   = 1'b0;
      gon_in       = 1'b0;
      goff_in      = 1'b0;
      if (cmd.finish) begin
         if (mode_ff == mlnps_pkg::MODE_ON) begin
            count_in     = finish_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
            cur_in       = note_ff;
            cur_valid_in = 1'b1;
            svel_in      = vel_clamped;
            pitch_in     = 1'b1;
            restart_in   = !active_ff;
            gon_in       = 1'b1;
         end else begin
            count_in = wr_ptr_ff;
            if (wr_ptr_ff != '0) begin
               if (hit) begin
                  cur_in   = last_ff;
                  pitch_in = 1'b1;
               end
            end else if (hit || !cur_valid_ff) begin
               goff_in      = 1'b1;
               cur_valid_in = 1'b0;
               cur_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         svel_ff      <= '0;
         pend_ff      <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
      end else begin
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         svel_ff      <= svel_in;
         pend_ff      <= pend_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (cmd.load) begin
         mode_ff   <= req_mode;
         note_ff   <= req_note;
         vel_ff    <= req_velocity;
         active_ff <= req_voice_active;
      end
      if (cmd.finish) begin
         rsp_sounding_note <= cur_valid_in ? cur_in : '0;
         rsp_note_valid    <= cur_valid_in;
         rsp_velocity_out  <= svel_in;
         rsp_pitch_update  <= pitch_in;
         rsp_restart_phase <= restart_in;
         rsp_gate_on       <= gon_in;
         rsp_gate_off      <= goff_in;
         rsp_held_total    <= mlnps_pkg::TOTAL_W'(count_in);
      end
   end

endmodule
`default_nettype wire

// File: rtl/mono_last_note_priority_stack.sv
// channel   dir  handshake              payload
// req_      in   req_valid / req_stall  mode, note, velocity, voice_active
// rsp_      out  rsp_valid / rsp_stall  sounding_note .. held_total
//
// a transaction is accepted in the idle state, then walks the held-note ram once to
// compact it, reading each held entry and writing back every entry that differs from
// the request note, then finishes and loads the output register
// a new request is taken while a finished response waits in the output register
// a finished transaction waits in its last cycle until the output register is free
// reset is synchronous, active high, and empties the stack and the voice state
`default_nettype none
module mono_last_note_priority_stack (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_mode,
   input  wire logic        [mlnps_pkg::NOTE_W-1:0]   req_note,
   input  wire logic signed [mlnps_pkg::VEL_W-1:0]    req_velocity,
   input  wire logic                                  req_voice_active,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [mlnps_pkg::NOTE_W-1:0]   rsp_sounding_note,
   output logic                                       rsp_note_valid,
   output logic             [mlnps_pkg::VOUT_W-1:0]   rsp_velocity_out,
   output logic                                       rsp_pitch_update,
   output logic                                       rsp_restart_phase,
   output logic                                       rsp_gate_on,
   output logic                                       rsp_gate_off,
   output logic             [mlnps_pkg::TOTAL_W-1:0]  rsp_held_total
);

   mlnps_pkg::cmd_type    cmd;
   mlnps_pkg::status_type status;

   mlnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mlnps_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_note          (req_note),
      .req_velocity      (req_velocity),
      .req_voice_active  (req_voice_active),
      .rsp_sounding_note (rsp_sounding_note),
      .rsp_note_valid    (rsp_note_valid),
      .rsp_velocity_out  (rsp_velocity_out),
      .rsp_pitch_update  (rsp_pitch_update),
      .rsp_restart_phase (rsp_restart_phase),
      .rsp_gate_on       (rsp_gate_on),
      .rsp_gate_off      (rsp_gate_off),
      .rsp_held_total    (rsp_held_total)
   );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 1300;
   localparam int SCRIPT_ROWS    = 25;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_EVERY    = 300;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic [mlnps_pkg::NOTE_W-1:0]  sounding_note;
      logic                          note_valid;
      logic [mlnps_pkg::VOUT_W-1:0]  velocity_out;
      logic                          pitch_update;
      logic                          restart_phase;
      logic                          gate_on;
      logic                          gate_off;
      logic [mlnps_pkg::TOTAL_W-1:0] held_total;
   } voice_update_type;

   typedef struct packed {
      logic                         mode;
      logic [mlnps_pkg::NOTE_W-1:0] note;
      logic [mlnps_pkg::VEL_W-1:0]  velocity;
      logic                         active;
      logic                         typed;
      voice_update_type             want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_mode = 1'b0;
   logic [mlnps_pkg::NOTE_W-1:0]         req_note = '0;
   logic signed [mlnps_pkg::VEL_W-1:0]   req_velocity = '0;
   logic                                 req_voice_active = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [mlnps_pkg::NOTE_W-1:0]         rsp_sounding_note;
   logic                                 rsp_note_valid;
   logic [mlnps_pkg::VOUT_W-1:0]         rsp_velocity_out;
   logic                                 rsp_pitch_update;
   logic                                 rsp_restart_phase;
   logic                                 rsp_gate_on;
   logic                                 rsp_gate_off;
   logic [mlnps_pkg::TOTAL_W-1:0]        rsp_held_total;

   mono_last_note_priority_stack uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_note          (req_note),
      .req_velocity      (req_velocity),
      .req_voice_active  (req_voice_active),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sounding_note (rsp_sounding_note),
      .rsp_note_valid    (rsp_note_valid),
      .rsp_velocity_out  (rsp_velocity_out),
      .rsp_pitch_update  (rsp_pitch_update),
      .rsp_restart_phase (rsp_restart_phase),
      .rsp_gate_on       (rsp_gate_on),
      .rsp_gate_off      (rsp_gate_off),
      .rsp_held_total    (rsp_held_total)
   );

   always #2 clock = ~clock;

   // note stack mirror
   logic [mlnps_pkg::NOTE_W-1:0]  stack_notes [mlnps_pkg::MAX_HELD];
   int                            stack_depth = 0;
   logic [mlnps_pkg::NOTE_W-1:0]  lead_note = '0;
   logic                          lead_valid = 1'b0;
   logic [mlnps_pkg::VOUT_W-1:0]  held_velocity = '0;

   voice_update_type   voice_updates [$];
   script_row_type     script_rows [SCRIPT_ROWS];
   int                 sent_count = 0;
   int                 mismatch_count = 0;
   int                 quiet_cycles = 0;
   bit                 calm_phase = 1'b0;

   function automatic voice_update_type predict_voice(
         input logic mode,
         input logic [mlnps_pkg::NOTE_W-1:0] note,
         input logic [mlnps_pkg::VEL_W-1:0] vel,
         input logic active);
      voice_update_type upd;
      int               wr;
      logic             hit;
      upd = '0;
      wr = 0;
      for (int rd = 0; rd < stack_depth; rd++) begin
         if (stack_notes[rd] != note) begin
            stack_notes[wr] = stack_notes[rd];
            wr++;
         end
      end
      stack_depth = wr;
      if (mode == mlnps_pkg::MODE_ON) begin
         if (stack_depth < mlnps_pkg::MAX_HELD) begin
            stack_notes[stack_depth] = note;
            stack_depth++;
         end
         lead_note = note;
         lead_valid = 1'b1;
         if (vel[mlnps_pkg::VEL_W-1])
            held_velocity = '0;
         else if (vel[mlnps_pkg::VOUT_W-1:0] > mlnps_pkg::VEL_FULL)
            held_velocity = mlnps_pkg::VEL_FULL;
         else
            held_velocity = vel[mlnps_pkg::VOUT_W-1:0];
         upd.pitch_update = 1'b1;
         upd.restart_phase = ~active;
         upd.gate_on = 1'b1;
      end else begin
         hit = lead_valid && (lead_note == note);
         if (stack_depth > 0) begin
            if (hit) begin
               lead_note = stack_notes[stack_depth-1];
               upd.pitch_update = 1'b1;
            end
         end else if (hit || !lead_valid) begin
            upd.gate_off = 1'b1;
            lead_valid = 1'b0;
            lead_note = '0;
         end
      end
      upd.sounding_note = lead_valid ? lead_note : '0;
      upd.note_valid = lead_valid;
      upd.velocity_out = held_velocity;
      upd.held_total = mlnps_pkg::TOTAL_W'(stack_depth);
      return upd;
   endfunction

   function automatic logic [mlnps_pkg::VEL_W-1:0] pick_velocity();
      logic [mlnps_pkg::VEL_W-1:0] v;
      case ($urandom_range(0, 4))
         0, 1: v = mlnps_pkg::VEL_W'($urandom_range(0, 16384));
         2: v = mlnps_pkg::VEL_W'($urandom());
         3: v = mlnps_pkg::VEL_W'($urandom_range(16380, 16400));
         default: begin
            case ($urandom_range(0, 5))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'hffff;
               3: v = 16'd16384;
               4: v = 16'd16385;
               default: v = 16'h0000;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_event(input logic mode, input logic [mlnps_pkg::NOTE_W-1:0] note,
                             input logic [mlnps_pkg::VEL_W-1:0] vel, input logic active,
                             input logic typed, input voice_update_type want);
      int unsigned      gap;
      voice_update_type predicted;
      gap = calm_phase ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_note         <= note;
      req_velocity     <= vel;
      req_voice_active <= active;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_voice(mode, note, vel, active);
      voice_updates.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic send_plain(input logic mode, input logic [mlnps_pkg::NOTE_W-1:0] note,
                             input logic [mlnps_pkg::VEL_W-1:0] vel, input logic active);
      send_event(mode, note, vel, active, 1'b0, '0);
   endtask

   task automatic drain_voice_updates();
      req_valid <= 1'b0;
      while (voice_updates.size() != 0) @(posedge clock);
   endtask

   // phrase: note-ons and releases over a small pool, with occasional stray releases, then release all
   task automatic play_phrase();
      logic [mlnps_pkg::NOTE_W-1:0] pool [20];
      logic [mlnps_pkg::NOTE_W-1:0] held_q [$];
      logic [mlnps_pkg::NOTE_W-1:0] n;
      int unsigned                  pool_size;
      int unsigned                  steps;
      int                           idx;
      pool_size = $urandom_range(1, 20);
      for (int i = 0; i < 20; i++)
         pool[i] = mlnps_pkg::NOTE_W'($urandom_range(0, 127));
      steps = $urandom_range(4, 40);
      repeat (steps) begin
         if (held_q.size() == 0 || $urandom_range(0, 2) != 0) begin
            n = pool[$urandom_range(0, pool_size - 1)];
            send_plain(mlnps_pkg::MODE_ON, n, pick_velocity(),
                       lead_valid ^ ($urandom_range(0, 7) == 0));
            held_q.push_back(n);
         end else if ($urandom_range(0, 9) == 0) begin
            send_plain(mlnps_pkg::MODE_OFF, pool[$urandom_range(0, pool_size - 1)],
                       mlnps_pkg::VEL_W'($urandom()),
                       lead_valid ^ ($urandom_range(0, 7) == 0));
         end else begin
            idx = $urandom_range(0, held_q.size() - 1);
            n = held_q[idx];
            held_q.delete(idx);
            send_plain(mlnps_pkg::MODE_OFF, n, mlnps_pkg::VEL_W'($urandom()),
                       lead_valid ^ ($urandom_range(0, 7) == 0));
         end
      end
      while (held_q.size() != 0) begin
         idx = $urandom_range(0, held_q.size() - 1);
         n = held_q[idx];
         held_q.delete(idx);
         send_plain(mlnps_pkg::MODE_OFF, n, mlnps_pkg::VEL_W'($urandom()),
                    lead_valid ^ ($urandom_range(0, 7) == 0));
      end
   endtask

   task automatic field_check(input string fname, input logic [31:0] expv,
                              input logic [31:0] actv);
      if (expv !== actv) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, fname, expv, actv);
      end
   endtask

   initial begin
      int next_drain;
      script_rows[0] = '{mlnps_pkg::MODE_OFF, 7'd60, 16'h0000, 1'b0, 1'b1,
                         '{7'd0, 1'b0, 15'd0, 1'b0, 1'b0, 1'b0, 1'b1, 5'd0}};
      script_rows[1] = '{mlnps_pkg::MODE_ON, 7'd0, 16'h8000, 1'b0, 1'b1,
                         '{7'd0, 1'b1, 15'd0, 1'b1, 1'b1, 1'b1, 1'b0, 5'd1}};
      script_rows[2] = '{mlnps_pkg::MODE_OFF, 7'd5, 16'h0000, 1'b1, 1'b1,
                         '{7'd0, 1'b1, 15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd1}};
      script_rows[3] = '{mlnps_pkg::MODE_ON, 7'd127, 16'h7fff, 1'b1, 1'b1,
                         '{7'd127, 1'b1, 15'd16384, 1'b1, 1'b0, 1'b1, 1'b0, 5'd2}};
      script_rows[4] = '{mlnps_pkg::MODE_ON, 7'd127, 16'd16385, 1'b1, 1'b1,
                         '{7'd127, 1'b1, 15'd16384, 1'b1, 1'b0, 1'b1, 1'b0, 5'd2}};
      script_rows[5] = '{mlnps_pkg::MODE_OFF, 7'd127, 16'hffff, 1'b1, 1'b1,
                         '{7'd0, 1'b1, 15'd16384, 1'b1, 1'b0, 1'b0, 1'b0, 5'd1}};
      script_rows[6] = '{mlnps_pkg::MODE_ON, 7'd64, 16'hffff, 1'b0, 1'b1,
                         '{7'd64, 1'b1, 15'd0, 1'b1, 1'b1, 1'b1, 1'b0, 5'd2}};
      script_rows[7] = '{mlnps_pkg::MODE_OFF, 7'd0, 16'h5555, 1'b1, 1'b1,
                         '{7'd64, 1'b1, 15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd1}};
      // fill the stack up to the limit
      for (int i = 0; i < 15; i++)
         script_rows[8+i] = '{mlnps_pkg::MODE_ON, mlnps_pkg::NOTE_W'(100 + i),
                              mlnps_pkg::VEL_W'(i * 2500) - 16'd3000,
                              1'(i % 2), 1'b0, '0};
      // stack full: sounds but is not stored
      script_rows[23] = '{mlnps_pkg::MODE_ON, 7'd50, 16'd100, 1'b1, 1'b1,
                          '{7'd50, 1'b1, 15'd100, 1'b1, 1'b0, 1'b1, 1'b0, 5'd16}};
      script_rows[24] = '{mlnps_pkg::MODE_OFF, 7'd50, 16'h0000, 1'b1, 1'b1,
                          '{7'd114, 1'b1, 15'd100, 1'b1, 1'b0, 1'b0, 1'b0, 5'd16}};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         send_event(script_rows[i].mode, script_rows[i].note, script_rows[i].velocity,
                    script_rows[i].active, script_rows[i].typed, script_rows[i].want);
      drain_voice_updates();

      next_drain = sent_count + DRAIN_EVERY;
      while (sent_count < SCRIPT_ROWS + RANDOM_ITEMS) begin
         calm_phase = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            play_phrase();
         end else begin
            repeat ($urandom_range(1, 8))
               send_plain(1'($urandom_range(0, 1)),
                          mlnps_pkg::NOTE_W'($urandom_range(0, 127)),
                          mlnps_pkg::VEL_W'($urandom()), 1'($urandom_range(0, 1)));
         end
         if (sent_count >= next_drain) begin
            drain_voice_updates();
            next_drain = sent_count + DRAIN_EVERY;
         end
      end

      drain_voice_updates();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned      hold;
      voice_update_type want;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = calm_phase ? 0 : $urandom_range(0, 19);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (rsp_valid !== 1'b1 || rsp_stall) @(posedge clock);
         if (voice_updates.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, expected none actual note %0d",
                     $realtime, rsp_sounding_note);
         end else begin
            want = voice_updates.pop_front();
            field_check("sounding_note", want.sounding_note, rsp_sounding_note);
            field_check("note_valid", want.note_valid, rsp_note_valid);
            field_check("velocity_out", want.velocity_out, rsp_velocity_out);
            field_check("pitch_update", want.pitch_update, rsp_pitch_update);
            field_check("restart_phase", want.restart_phase, rsp_restart_phase);
            field_check("gate_on", want.gate_on, rsp_gate_on);
            field_check("gate_off", want.gate_off, rsp_gate_off);
            field_check("held_total", want.held_total, rsp_held_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
`default_nettype wire
